// ===== rtl/sm4_pkg.sv =====
// SM4 shared definitions: sizes, register indexes, control struct and the
// S-box, tau, L, L' and CK helpers used by the key schedule and round core.
// No dependencies.
`timescale 1ns / 1ps

package sm4_pkg;

	localparam int ROUND_COUNT = 32;
	localparam int RK_IDX_W    = $clog2(ROUND_COUNT);
	localparam int WORD_W      = 32;
	localparam int HALF_W      = 64;
	localparam int CFG_IDX_W   = 2;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_UPPER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LOWER = 2'd1;

	localparam logic [RK_IDX_W-1:0] RK_LAST = RK_IDX_W'(ROUND_COUNT - 1);

	localparam logic [WORD_W-1:0] FK0 = 32'ha3b1bac6;
	localparam logic [WORD_W-1:0] FK1 = 32'h56aa3350;
	localparam logic [WORD_W-1:0] FK2 = 32'h677d9197;
	localparam logic [WORD_W-1:0] FK3 = 32'hb27022dc;

	typedef struct packed {
		logic                load;
		logic                step;
		logic [RK_IDX_W-1:0] idx;
	} sm4_ctl_t;

	localparam logic [7:0] SBOX [256] = '{
		8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
		8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
		8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
		8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
		8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
		8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
		8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
		8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
		8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
		8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
		8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
		8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
		8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
		8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
		8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
		8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
	};

	function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] v, input int n);
		rotl32 = (v << n) | (v >> (WORD_W - n));
	endfunction

	// tau: byte-wise S-box
	function automatic logic [WORD_W-1:0] subst_word(input logic [WORD_W-1:0] v);
		subst_word = {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
	endfunction

	function automatic logic [WORD_W-1:0] lin_data(input logic [WORD_W-1:0] b);
		lin_data = b ^ rotl32(b, 2) ^ rotl32(b, 10) ^ rotl32(b, 18) ^ rotl32(b, 24);
	endfunction

	function automatic logic [WORD_W-1:0] lin_key(input logic [WORD_W-1:0] b);
		lin_key = b ^ rotl32(b, 13) ^ rotl32(b, 23);
	endfunction

	// CK byte j of word i is (4i + j) * 7 mod 256
	function automatic logic [WORD_W-1:0] ck_word(input logic [RK_IDX_W-1:0] i);
		logic [WORD_W-1:0] w;
		w = '0;
		for (int j = 0; j < 4; j++) begin
			w = {w[23:0], 8'({1'b0, i, 2'(j)} * 8'd7)};
		end
		ck_word = w;
	endfunction

endpackage

// ===== rtl/sm4_block_cipher_unit.sv =====
// SM4 block cipher unit, top level: key registers, sequencer, round-key RAM,
// key schedule, round core and output register. Depends on sm4_pkg and submodules.
//
//  channel  signals                               width      direction
//  in       in_valid/in_ready, func, block_*      1+64+64    in
//  out      out_valid/out_ready, out_upper/lower  64+64      out
//  cfg      cfg_we, cfg_idx, cfg_data             2+64       in
//
// With the round keys ready an accepted word runs through the 32 rounds, one round key
// read from the RAM per cycle; out_valid rises once the last round's result is registered.
// The first block after reset or a key write first runs the key expansion
// (one round key written per cycle, then a prefetch state that reads the first key).
// A waiting result holds the core in its last state until out_ready; the next
// word is accepted as soon as the result has moved to the output register.
// The round-key RAM has no reset; reset clears the key registers and key-ready.
`timescale 1ns / 1ps

module sm4_block_cipher_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [sm4_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [sm4_pkg::HALF_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          func,
	input  logic [sm4_pkg::HALF_W-1:0]    block_upper,
	input  logic [sm4_pkg::HALF_W-1:0]    block_lower,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [sm4_pkg::HALF_W-1:0]    out_upper,
	output logic [sm4_pkg::HALF_W-1:0]    out_lower
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EXP   = 3'd1;
	localparam logic [2:0] ST_PREF  = 3'd2;
	localparam logic [2:0] ST_RUN   = 3'd3;
	localparam logic [2:0] ST_DRAIN = 3'd4;

	logic [2:0]                    state_q;
	logic [sm4_pkg::RK_IDX_W-1:0]  cnt_q;
	logic                          keys_ready_q;
	logic                          dec_q;
	logic [sm4_pkg::HALF_W-1:0]    key_upper_q;
	logic [sm4_pkg::HALF_W-1:0]    key_lower_q;
	logic                          out_valid_q;
	logic [sm4_pkg::HALF_W-1:0]    out_upper_q;
	logic [sm4_pkg::HALF_W-1:0]    out_lower_q;

	logic                          in_fire;
	logic                          out_free;
	logic                          last_cnt;
	logic                          dec;
	logic [sm4_pkg::RK_IDX_W-1:0]  rd_pos;
	logic [sm4_pkg::RK_IDX_W-1:0]  rd_addr;
	logic [sm4_pkg::WORD_W-1:0]    rk_rd;
	logic [sm4_pkg::WORD_W-1:0]    rk_wr;
	logic [4*sm4_pkg::WORD_W-1:0]  x_words;
	logic [sm4_pkg::WORD_W-1:0]    x_next;
	sm4_pkg::sm4_ctl_t             kctl;
	sm4_pkg::sm4_ctl_t             dctl;
	logic                          load_fin;
	logic                          load_drain;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid & in_ready;
	assign out_free  = ~out_valid_q | out_ready;
	assign last_cnt  = (cnt_q == sm4_pkg::RK_LAST);
	assign out_valid = out_valid_q;
	assign out_upper = out_upper_q;
	assign out_lower = out_lower_q;

	assign load_fin   = (state_q == ST_RUN) & last_cnt & out_free;
	assign load_drain = (state_q == ST_DRAIN) & out_free;

	// prefetch the key for the round after this one; decrypt walks down
	assign dec     = (state_q == ST_IDLE) ? func : dec_q;
	assign rd_pos  = (state_q == ST_RUN) ? cnt_q + 1'b1 : '0;
	assign rd_addr = dec ? sm4_pkg::RK_LAST - rd_pos : rd_pos;

	assign kctl.load = in_fire;
	assign kctl.step = (state_q == ST_EXP);
	assign kctl.idx  = cnt_q;

	assign dctl.load = in_fire;
	assign dctl.step = (state_q == ST_RUN);
	assign dctl.idx  = cnt_q;

	sm4_rk_ram #(
		.DEPTH(sm4_pkg::ROUND_COUNT),
		.WIDTH(sm4_pkg::WORD_W)
	) u_ram (
		.clk  (clk),
		.we   (kctl.step),
		.waddr(cnt_q),
		.wdata(rk_wr),
		.raddr(rd_addr),
		.rdata(rk_rd)
	);

	sm4_key_exp u_key (
		.clk      (clk),
		.ctl      (kctl),
		.key_upper(key_upper_q),
		.key_lower(key_lower_q),
		.rk_next  (rk_wr)
	);

	sm4_round u_round (
		.clk        (clk),
		.ctl        (dctl),
		.block_upper(block_upper),
		.block_lower(block_lower),
		.rk         (rk_rd),
		.x_words    (x_words),
		.x_next     (x_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			keys_ready_q <= 1'b0;
			dec_q        <= 1'b0;
			key_upper_q  <= '0;
			key_lower_q  <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we && cfg_idx == sm4_pkg::REG_KEY_UPPER) begin
				key_upper_q  <= cfg_data;
				keys_ready_q <= 1'b0;
			end else if (cfg_we && cfg_idx == sm4_pkg::REG_KEY_LOWER) begin
				key_lower_q  <= cfg_data;
				keys_ready_q <= 1'b0;
			end else if (state_q == ST_EXP && last_cnt) begin
				keys_ready_q <= 1'b1;
			end

			if (load_fin || load_drain) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						dec_q   <= func;
						cnt_q   <= '0;
						state_q <= keys_ready_q ? ST_RUN : ST_EXP;
					end
				end
				ST_EXP: begin
					cnt_q <= cnt_q + 1'b1;
					if (last_cnt) begin
						state_q <= ST_PREF;
					end
				end
				ST_PREF: begin
					cnt_q   <= '0;
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					// finish the last round, then wait in drain while the output register is full
					if (last_cnt) begin
						state_q <= out_free ? ST_IDLE : ST_DRAIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result is X35..X32: reverse the final four words
	always_ff @(posedge clk) begin
		if (load_fin) begin
			out_upper_q <= {x_next, x_words[127:96]};
			out_lower_q <= {x_words[95:64], x_words[63:32]};
		end else if (load_drain) begin
			out_upper_q <= {x_words[127:96], x_words[95:64]};
			out_lower_q <= {x_words[63:32], x_words[31:0]};
		end
	end

endmodule

// ===== rtl/sm4_rk_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM, registered read.
// Holds the SM4 round keys; no dependencies.
`timescale 1ns / 1ps

module sm4_rk_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/sm4_key_exp.sv =====
// SM4 key schedule: one round key per step from the FK-masked key words.
// Depends on sm4_pkg.
`timescale 1ns / 1ps

module sm4_key_exp (
	input  logic                     clk,
	input  sm4_pkg::sm4_ctl_t        ctl,
	input  logic [sm4_pkg::HALF_W-1:0] key_upper,
	input  logic [sm4_pkg::HALF_W-1:0] key_lower,
	output logic [sm4_pkg::WORD_W-1:0] rk_next
);

	logic [sm4_pkg::WORD_W-1:0] k_q [4];

	assign rk_next = k_q[0] ^ sm4_pkg::lin_key(sm4_pkg::subst_word(
		k_q[1] ^ k_q[2] ^ k_q[3] ^ sm4_pkg::ck_word(ctl.idx)));

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			k_q[0] <= key_upper[63:32] ^ sm4_pkg::FK0;
			k_q[1] <= key_upper[31:0]  ^ sm4_pkg::FK1;
			k_q[2] <= key_lower[63:32] ^ sm4_pkg::FK2;
			k_q[3] <= key_lower[31:0]  ^ sm4_pkg::FK3;
		end else if (ctl.step) begin
			k_q[0] <= k_q[1];
			k_q[1] <= k_q[2];
			k_q[2] <= k_q[3];
			k_q[3] <= rk_next;
		end
	end

endmodule

// ===== rtl/sm4_round.sv =====
// SM4 data round: one application of F per step, round key from the store.
// Depends on sm4_pkg.
`timescale 1ns / 1ps

module sm4_round (
	input  logic                       clk,
	input  sm4_pkg::sm4_ctl_t          ctl,
	input  logic [sm4_pkg::HALF_W-1:0] block_upper,
	input  logic [sm4_pkg::HALF_W-1:0] block_lower,
	input  logic [sm4_pkg::WORD_W-1:0] rk,
	output logic [4*sm4_pkg::WORD_W-1:0] x_words,
	output logic [sm4_pkg::WORD_W-1:0] x_next
);

	logic [sm4_pkg::WORD_W-1:0] x_q [4];

	assign x_next = x_q[0] ^ sm4_pkg::lin_data(sm4_pkg::subst_word(
		x_q[1] ^ x_q[2] ^ x_q[3] ^ rk));
	assign x_words = {x_q[3], x_q[2], x_q[1], x_q[0]};

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			x_q[0] <= block_upper[63:32];
			x_q[1] <= block_upper[31:0];
			x_q[2] <= block_lower[63:32];
			x_q[3] <= block_lower[31:0];
		end else if (ctl.step) begin
			x_q[0] <= x_q[1];
			x_q[1] <= x_q[2];
			x_q[2] <= x_q[3];
			x_q[3] <= x_next;
		end
	end

endmodule

// ===== rtl/sm4_chk.sv =====
// Port-level checker for the SM4 block cipher unit, bound to the top level.
// Depends on sm4_pkg for port widths.
`timescale 1ns / 1ps

module sm4_chk (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  logic [sm4_pkg::HALF_W-1:0] out_upper,
	input  logic [sm4_pkg::HALF_W-1:0] out_lower
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_upper) && $stable(out_lower))
		else $error("result word changed while stalled");

	// one word at a time: busy right after an accept
	a_busy_next: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while a word is in flight");

	// all 32 rounds run before the next accept
	a_busy_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> ##32 !in_ready)
		else $error("input ready before the rounds completed");

endmodule

bind sm4_block_cipher_unit sm4_chk u_sm4_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_upper(out_upper),
	.out_lower(out_lower)
);
